// ----- hdl/bmwq_pkg.sv -----
// Shared types and constants for the blocking mailbox with waiter queue.
// Used by bmwq_front, bmwq_back and blocking_mailbox_wait_queue_top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmwq_pkg;

    localparam int WAITER_DEPTH_DEF = 16;
    localparam int THREAD_COUNT_DEF = 64;

    localparam int MODE_W   = 2;
    localparam int TID_W    = 6;
    localparam int MSG_W    = 32;
    localparam int STATUS_W = 3;
    localparam int TID_NUM  = 1 << TID_W;
    localparam int CMD_DEPTH = 2;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_RECV  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BCAST = 2'd2;

    typedef enum logic [1:0] {
        OP_RECV  = 2'd0,
        OP_SEND  = 2'd1,
        OP_BCAST = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOT     = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_STORED  = 3'd2,
        ST_WOKE    = 3'd3,
        ST_FULL    = 3'd4,
        ST_QFULL   = 3'd5
    } t_status;

    typedef struct packed {
        t_op                      op;
        logic [TID_W-1:0]         tid;
        logic signed [MSG_W-1:0]  msg;
    } t_cmd;

    typedef logic [TID_NUM-1:0][TID_W-1:0] t_tid_lut;

    // Thread id reduced modulo the thread count, built at elaboration
    // with a wrapping counter.
    function automatic t_tid_lut build_tid_lut(input int tc);
        t_tid_lut lut;
        int       r;
        r = 0;
        for (int i = 0; i < TID_NUM; i++) begin
            lut[i] = TID_W'(r);
            r = (r + 1 >= tc) ? 0 : r + 1;
        end
        return lut;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bmwq_front.sv -----
// Front end: accepts input transfers, decodes the mode, drops unused codes
// and buffers commands in a two-entry queue. Depends on bmwq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmwq_front #(
    parameter int THREAD_COUNT = bmwq_pkg::THREAD_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bmwq_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [bmwq_pkg::TID_W-1:0]        i_thread_id,
    input  wire logic signed [bmwq_pkg::MSG_W-1:0] i_message,
    output logic                                   o_cmd_valid,
    output bmwq_pkg::t_cmd                         o_cmd,
    input  wire logic                              i_cmd_pop
);

    localparam int PTR_W = $clog2(bmwq_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(bmwq_pkg::CMD_DEPTH + 1);
    localparam bmwq_pkg::t_tid_lut TidLut = bmwq_pkg::build_tid_lut(THREAD_COUNT);

    bmwq_pkg::t_cmd   r_q [bmwq_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    bmwq_pkg::t_cmd cmd_in;
    logic           keep;
    logic           push;
    logic           pop;

    always_comb begin
        cmd_in.tid = TidLut[i_thread_id];
        cmd_in.msg = i_message;
        cmd_in.op  = bmwq_pkg::OP_RECV;
        keep       = 1'b1;
        unique case (i_mode)
            bmwq_pkg::MODE_RECV:  cmd_in.op = bmwq_pkg::OP_RECV;
            bmwq_pkg::MODE_SEND:  cmd_in.op = bmwq_pkg::OP_SEND;
            bmwq_pkg::MODE_BCAST: cmd_in.op = bmwq_pkg::OP_BCAST;
            default:              keep      = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_count == CNT_W'(bmwq_pkg::CMD_DEPTH));
    assign push        = i_in_valid && !o_in_stall && keep;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(bmwq_pkg::CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(bmwq_pkg::CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bmwq_back.sv -----
// Back end: mailbox slot, waiter ring in a small memory, command sequencer
// and the result register. Depends on bmwq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmwq_back #(
    parameter int WAITER_DEPTH = bmwq_pkg::WAITER_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire bmwq_pkg::t_cmd               i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [bmwq_pkg::STATUS_W-1:0]     o_status,
    output logic [bmwq_pkg::TID_W-1:0]        o_woken_thread,
    output logic signed [bmwq_pkg::MSG_W-1:0] o_value,
    output logic                              o_last
);

    localparam int IDX_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int CNT_W = $clog2(WAITER_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_BCAST = 3'b100
    } t_bstate;

    t_bstate                         r_state, n_state;
    bmwq_pkg::t_cmd                  r_cmd, n_cmd;
    logic signed [bmwq_pkg::MSG_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]                r_head, n_head;
    logic [IDX_W-1:0]                r_tail, n_tail;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [bmwq_pkg::TID_W-1:0]      r_wait_mem [WAITER_DEPTH];
    logic [bmwq_pkg::TID_W-1:0]      r_head_id;

    logic                            r_out_valid, n_out_valid;
    bmwq_pkg::t_status               r_out_status, n_out_status;
    logic [bmwq_pkg::TID_W-1:0]      r_out_woken, n_out_woken;
    logic signed [bmwq_pkg::MSG_W-1:0] r_out_value, n_out_value;
    logic                            r_out_last, n_out_last;

    logic             out_free;
    logic             slot_full;
    logic             mem_we;
    logic             emit;
    logic             wake_step;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        return (nxt >= (IDX_W + 1)'(WAITER_DEPTH)) ? '0 : nxt[IDX_W-1:0];
    endfunction

    assign out_free  = !r_out_valid || !i_out_stall;
    assign slot_full = (r_slot != '0) && !r_slot[bmwq_pkg::MSG_W-1];
    assign head_inc  = ring_next(r_head);
    assign tail_inc  = ring_next(r_tail);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        o_cmd_pop    = 1'b0;
        mem_we       = 1'b0;
        emit         = 1'b0;
        wake_step    = 1'b0;
        n_out_status = bmwq_pkg::ST_GOT;
        n_out_woken  = '0;
        n_out_value  = '0;
        n_out_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd.op)
                        bmwq_pkg::OP_RECV: begin
                            if (slot_full) begin
                                n_out_status = bmwq_pkg::ST_GOT;
                                n_out_value  = r_slot;
                                n_slot       = '0;
                            end else if (r_count == CNT_W'(WAITER_DEPTH)) begin
                                n_out_status = bmwq_pkg::ST_QFULL;
                            end else begin
                                mem_we       = 1'b1;
                                n_tail       = tail_inc;
                                n_count      = r_count + 1'b1;
                                n_out_status = bmwq_pkg::ST_BLOCKED;
                            end
                        end
                        bmwq_pkg::OP_SEND: begin
                            if (slot_full) begin
                                n_out_status = bmwq_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_slot       = r_cmd.msg;
                                n_out_status = bmwq_pkg::ST_STORED;
                            end else begin
                                n_out_status = bmwq_pkg::ST_WOKE;
                                n_out_woken  = r_head_id;
                                n_out_value  = r_cmd.msg;
                                n_head       = head_inc;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        bmwq_pkg::OP_BCAST: begin
                            if (slot_full) begin
                                n_out_status = bmwq_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_slot       = r_cmd.msg;
                                n_out_status = bmwq_pkg::ST_STORED;
                            end else begin
                                wake_step = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_BCAST: begin
                if (out_free) begin
                    emit      = 1'b1;
                    wake_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // One waiter of a broadcast per cycle while the result channel is not
        // stalled; the ring restarts at zero once the last one is handed the message.
        if (wake_step) begin
            n_out_status = bmwq_pkg::ST_WOKE;
            n_out_woken  = r_head_id;
            n_out_value  = r_cmd.msg;
            n_count      = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_out_last = 1'b1;
                n_head     = '0;
                n_tail     = '0;
                n_state    = S_IDLE;
            end else begin
                n_out_last = 1'b0;
                n_head     = head_inc;
                n_state    = S_BCAST;
            end
        end

        n_out_valid = r_out_valid && i_out_stall;
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (emit) begin
            r_out_status <= n_out_status;
            r_out_woken  <= n_out_woken;
            r_out_value  <= n_out_value;
            r_out_last   <= n_out_last;
        end
    end

    // Waiter ring: written at the tail, read at the next head.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wait_mem[r_tail] <= r_cmd.tid;
        end
        r_head_id <= r_wait_mem[n_head];
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_woken_thread = r_out_woken;
    assign o_value        = r_out_value;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/blocking_mailbox_wait_queue_top.sv -----
// Top level of the blocking mailbox. Depends on bmwq_pkg, bmwq_front, bmwq_back.
// A receive or send is queued, loaded into the sequencer, then executed with its result
//   written to the result register; the sequencer takes no new command until then. A
//   broadcast wakes one waiter read from the waiter memory per cycle while the result
//   channel is not stalled. Synchronous active-low reset empties the slot, the waiter
//   ring and the command queue; the waiter memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module blocking_mailbox_wait_queue_top #(
    parameter int WAITER_DEPTH = bmwq_pkg::WAITER_DEPTH_DEF,
    parameter int THREAD_COUNT = bmwq_pkg::THREAD_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input channel: transfer when i_in_valid is high and o_in_stall is low
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bmwq_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [bmwq_pkg::TID_W-1:0]        i_thread_id,
    input  wire logic signed [bmwq_pkg::MSG_W-1:0] i_message,
    // Result channel: transfer when o_out_valid is high and i_out_stall is low
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [bmwq_pkg::STATUS_W-1:0]          o_status,
    output logic [bmwq_pkg::TID_W-1:0]             o_woken_thread,
    output logic signed [bmwq_pkg::MSG_W-1:0]      o_value,
    output logic                                   o_last
);

    // Command path between the decoder and the sequencer. The front end
    // drops the unused mode code, so it produces no result at all.
    logic           cmd_valid;
    bmwq_pkg::t_cmd cmd;
    logic           cmd_pop;

    // Front end: input transfer, mode decode, thread id reduction and a
    // two-entry queue, so new input is taken while a result waits.
    bmwq_front #(
        .THREAD_COUNT (THREAD_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_thread_id (i_thread_id),
        .i_message   (i_message),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: slot, waiter ring and result register. It may load a command
    // while the result channel is stalled, but executes none until it is free.
    bmwq_back #(
        .WAITER_DEPTH (WAITER_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_woken_thread (o_woken_thread),
        .o_value        (o_value),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
